@@ rtl/ltc_pkg.sv @@
package ltc_pkg;

	// field widths fixed by the interface
	localparam int DUR_BITS     = 21;
	localparam int LC_BITS      = 11;
	localparam int LOOP_BITS    = 10;
	localparam int DELTA_BITS   = 16;
	localparam int SEEK_BITS    = 30;
	localparam int OP_BITS      = 3;
	localparam int CFG_IDX_BITS = 2;
	localparam int RS_BITS      = 2;
	// magnitude bits of a positive loop duration
	localparam int DIV_BITS     = DUR_BITS - 1;

	localparam logic [LOOP_BITS-1:0] LOOP_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION  = 2'd2;

	typedef enum logic [OP_BITS-1:0] {
		OP_TICK   = 3'd0,
		OP_START  = 3'd1,
		OP_STOP   = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_RESUME = 3'd4,
		OP_SEEK   = 3'd5
	} op_t;

	typedef enum logic [RS_BITS-1:0] {
		RS_STOP  = 2'd0,
		RS_PAUSE = 2'd1,
		RS_RUN   = 2'd2
	} run_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_SETUP,
		SEQ_DIV,
		SEQ_SPLIT,
		SEQ_FIN_MUL,
		SEQ_FIN_CHK,
		SEQ_DONE
	} seq_t;

endpackage

@@ rtl/ltc_div.sv @@
module ltc_div #(
	parameter int W = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [W-1:0]                  dividend,
	input  logic [ltc_pkg::DIV_BITS-1:0]  divisor,
	output logic                          done,
	output logic [W-1:0]                  quotient,
	output logic [ltc_pkg::DIV_BITS-1:0]  remainder
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic                          busy_q;
	logic                          done_q;
	logic [CW-1:0]                 cnt_q;
	logic [ltc_pkg::DIV_BITS-1:0]  rem_q;
	logic [W-1:0]                  quo_q;
	logic [ltc_pkg::DIV_BITS:0]    trial;
	logic [ltc_pkg::DIV_BITS:0]    diff;
	logic                          take;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		take  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[ltc_pkg::DIV_BITS-1:0] : trial[ltc_pkg::DIV_BITS-1:0];
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ rtl/looping_timeline_counter.sv @@
// Looping timeline counter. Keeps a total elapsed time and splits it into a loop
// number and a time within the loop, set up by the duration, loop count and
// direction registers. Each input transaction carries one operation (tick, start,
// stop, pause, resume, seek) and yields exactly one output transaction with the
// state after it. The block works on one transaction at a time: in_stall is high
// from acceptance until the result is loaded into the output register, and a new
// transaction can be taken while that result still waits. An operation that sets
// the time with a positive duration passes through the restoring divider, which
// resolves one quotient bit per cycle; one that ends in a stop also passes the
// completion check.
module looping_timeline_counter #(
	parameter int TIME_BITS = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ltc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ltc_pkg::DUR_BITS-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ltc_pkg::OP_BITS-1:0]       op,
	input  logic [ltc_pkg::DELTA_BITS-1:0]    delta_ms,
	input  logic [ltc_pkg::SEEK_BITS-1:0]     seek_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [TIME_BITS-1:0]              total_time,
	output logic [TIME_BITS-1:0]              loop_time,
	output logic [ltc_pkg::LOOP_BITS-1:0]     loop_index,
	output logic [ltc_pkg::RS_BITS-1:0]       run_state,
	output logic                              loop_changed,
	output logic                              finished
);

	localparam int TL_BITS = (TIME_BITS > ltc_pkg::DIV_BITS) ? TIME_BITS : ltc_pkg::DIV_BITS;
	localparam int WB      = ((TIME_BITS > 32) ? TIME_BITS : 32) + 2;
	localparam int FP_BITS = TL_BITS + ltc_pkg::LC_BITS;
	localparam int FC_BITS = (FP_BITS > 32) ? FP_BITS : 32;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	// configuration registers
	logic signed [ltc_pkg::DUR_BITS-1:0]  dur_q;
	logic signed [ltc_pkg::LC_BITS-1:0]   lc_q;
	logic                                 dir_q;

	// sequencer and item registers
	ltc_pkg::seq_t                        seq_q, seq_d;
	ltc_pkg::op_t                         op_q;
	logic [ltc_pkg::DELTA_BITS-1:0]       delta_q;
	logic [ltc_pkg::SEEK_BITS-1:0]        seek_q;
	logic signed [31:0]                   prod_q;
	logic [31:0]                          prod_u;
	logic [FP_BITS-1:0]                   fin_prod_q;
	logic [ltc_pkg::LOOP_BITS-1:0]        old_lp_q;

	// timeline state
	logic [TIME_BITS-1:0]                 total_q, total_d;
	logic [TL_BITS-1:0]                   tl_q, tl_d;
	logic [ltc_pkg::LOOP_BITS-1:0]        lp_q, lp_d;
	ltc_pkg::run_state_t                  st_q, st_d;
	logic                                 fin_q, fin_d;

	// output register
	logic                                 out_valid_q;
	logic                                 out_load;
	logic [TIME_BITS-1:0]                 total_time_q;
	logic [TIME_BITS-1:0]                 loop_time_q;
	logic [ltc_pkg::LOOP_BITS-1:0]        loop_index_q;
	ltc_pkg::run_state_t                  run_state_q;
	logic                                 loop_changed_q;
	logic                                 finished_q;

	// decoded configuration
	logic                                 in_accept;
	logic                                 dur_pos, dur_inf, lc_neg, lc_zero, lc_all;
	logic                                 unbounded;
	logic [ltc_pkg::DIV_BITS-1:0]         dur_mag;
	logic [TIME_BITS-1:0]                 tdur, dur_sat, rewind;
	logic signed [WB-1:0]                 raw;
	logic [TIME_BITS-1:0]                 tgt_sat, tgt;
	logic                                 set_go, stop_go;

	// divider and split results
	logic                                 div_start, div_done;
	logic [TIME_BITS-1:0]                 div_quo;
	logic [ltc_pkg::DIV_BITS-1:0]         div_rem;
	logic [TIME_BITS-1:0]                 q_use, q_dec;
	logic                                 q_eq_lc;
	logic [ltc_pkg::LOOP_BITS-1:0]        lp_of_q, lp_of_qdec;
	logic [TL_BITS-1:0]                   split_tl;
	logic [ltc_pkg::LOOP_BITS-1:0]        split_lp;
	logic                                 auto_stop, stop_ok;
	logic [ltc_pkg::LC_BITS-1:0]          lp_inc;
	logic                                 fin_fwd, fin_chk;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (seq_q != ltc_pkg::SEQ_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= '0;
			lc_q  <= ltc_pkg::LC_BITS'(1);
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ltc_pkg::CFG_DURATION:   dur_q <= cfg_data;
				ltc_pkg::CFG_LOOP_COUNT: lc_q  <= cfg_data[ltc_pkg::LC_BITS-1:0];
				ltc_pkg::CFG_DIRECTION:  dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// register decode
	always_comb begin
		dur_pos   = !dur_q[ltc_pkg::DUR_BITS-1] && (dur_q != '0);
		dur_inf   = (dur_q == '1);
		dur_mag   = dur_q[ltc_pkg::DIV_BITS-1:0];
		lc_neg    = lc_q[ltc_pkg::LC_BITS-1];
		lc_zero   = (lc_q == '0);
		lc_all    = (lc_q == '1);
		unbounded = dur_inf || (dur_pos && lc_neg);
		prod_u    = prod_q;
	end

	// total duration and rewind point, saturated to the time range
	always_comb begin
		if (dur_pos && !lc_neg)
			tdur = (WB'(prod_u) > WB'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(prod_u);
		else
			tdur = '0;
		dur_sat = (WB'(dur_mag) > WB'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(dur_mag);
		if (!dir_q)
			rewind = '0;
		else if (lc_all)
			rewind = dur_pos ? dur_sat : '0;
		else
			rewind = tdur;
	end

	// new target time and its clamp
	always_comb begin
		case (op_q)
			ltc_pkg::OP_TICK:
				raw = dir_q ? $signed(WB'(total_q)) - $signed(WB'(delta_q))
				            : $signed(WB'(total_q)) + $signed(WB'(delta_q));
			ltc_pkg::OP_SEEK: raw = $signed(WB'(seek_q));
			default:          raw = $signed(WB'(rewind));
		endcase
		if (raw[WB-1])
			tgt_sat = '0;
		else if (raw > $signed(WB'(TIME_MAX)))
			tgt_sat = TIME_MAX;
		else
			tgt_sat = TIME_BITS'(raw);
		tgt = (!unbounded && (tgt_sat > tdur)) ? tdur : tgt_sat;
	end

	ltc_div #(
		.W (TIME_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (tgt),
		.divisor   (dur_mag),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// split the total into loop number and time in loop
	always_comb begin
		q_use      = dur_pos ? div_quo : '0;
		q_dec      = q_use - TIME_BITS'(1);
		q_eq_lc    = !lc_neg && (q_use == TIME_BITS'(lc_q[ltc_pkg::LOOP_BITS-1:0]));
		lp_of_q    = (q_use > TIME_BITS'(ltc_pkg::LOOP_MAX)) ? ltc_pkg::LOOP_MAX
		                                                     : q_use[ltc_pkg::LOOP_BITS-1:0];
		lp_of_qdec = (q_dec > TIME_BITS'(ltc_pkg::LOOP_MAX)) ? ltc_pkg::LOOP_MAX
		                                                     : q_dec[ltc_pkg::LOOP_BITS-1:0];
		if (q_eq_lc) begin
			split_tl = dur_pos ? TL_BITS'(dur_mag) : '0;
			split_lp = lc_zero ? '0
			                   : lc_q[ltc_pkg::LOOP_BITS-1:0] - ltc_pkg::LOOP_BITS'(1);
		end else if (!dur_pos) begin
			split_tl = TL_BITS'(total_q);
			split_lp = '0;
		end else if (!dir_q) begin
			split_tl = TL_BITS'(div_rem);
			split_lp = lp_of_q;
		end else if (total_q == '0) begin
			split_tl = '0;
			split_lp = lp_of_q;
		end else if (div_rem == '0) begin
			// backward end of loop: a whole loop shows as full, one loop lower
			split_tl = TL_BITS'(dur_mag);
			split_lp = lp_of_qdec;
		end else begin
			split_tl = TL_BITS'(div_rem);
			split_lp = lp_of_q;
		end
		auto_stop = (!dir_q && !unbounded && (total_q == tdur)) || (dir_q && (total_q == '0));
		stop_ok   = (st_q != ltc_pkg::RS_STOP) && !lc_zero;
	end

	// completion test on a stop
	always_comb begin
		lp_inc  = ltc_pkg::LC_BITS'(lp_q) + ltc_pkg::LC_BITS'(1);
		fin_fwd = !dir_q && !prod_q[31] && (FC_BITS'(fin_prod_q) == FC_BITS'(prod_u));
		fin_chk = dur_inf || lc_neg || fin_fwd || (dir_q && (tl_q == '0));
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= ltc_pkg::SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	// sequencer next state and state updates
	always_comb begin
		seq_d     = seq_q;
		total_d   = total_q;
		tl_d      = tl_q;
		lp_d      = lp_q;
		st_d      = st_q;
		fin_d     = fin_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		set_go    = 1'b0;
		stop_go   = 1'b0;
		case (seq_q)
			ltc_pkg::SEQ_IDLE: begin
				if (in_valid) begin
					fin_d = 1'b0;
					seq_d = ltc_pkg::SEQ_MUL;
				end
			end
			ltc_pkg::SEQ_MUL: begin
				seq_d = ltc_pkg::SEQ_SETUP;
			end
			ltc_pkg::SEQ_SETUP: begin
				case (op_q)
					ltc_pkg::OP_TICK: begin
						set_go = (st_q == ltc_pkg::RS_RUN) && (delta_q != '0);
					end
					ltc_pkg::OP_START: begin
						if ((st_q != ltc_pkg::RS_RUN) && !lc_zero) begin
							st_d   = ltc_pkg::RS_RUN;
							set_go = (st_q == ltc_pkg::RS_STOP);
						end
					end
					ltc_pkg::OP_STOP: begin
						stop_go = (st_q != ltc_pkg::RS_STOP) && !lc_zero;
					end
					ltc_pkg::OP_PAUSE: begin
						if ((st_q == ltc_pkg::RS_RUN) && !lc_zero)
							st_d = ltc_pkg::RS_PAUSE;
					end
					ltc_pkg::OP_RESUME: begin
						if ((st_q == ltc_pkg::RS_PAUSE) && !lc_zero)
							st_d = ltc_pkg::RS_RUN;
					end
					ltc_pkg::OP_SEEK: begin
						set_go = 1'b1;
					end
					default: ;
				endcase
				if (set_go) begin
					total_d = tgt;
					if (dur_pos) begin
						div_start = 1'b1;
						seq_d     = ltc_pkg::SEQ_DIV;
					end else begin
						seq_d = ltc_pkg::SEQ_SPLIT;
					end
				end else if (stop_go) begin
					seq_d = ltc_pkg::SEQ_FIN_MUL;
				end else begin
					seq_d = ltc_pkg::SEQ_DONE;
				end
			end
			ltc_pkg::SEQ_DIV: begin
				if (div_done)
					seq_d = ltc_pkg::SEQ_SPLIT;
			end
			ltc_pkg::SEQ_SPLIT: begin
				tl_d  = split_tl;
				lp_d  = split_lp;
				seq_d = (auto_stop && stop_ok) ? ltc_pkg::SEQ_FIN_MUL : ltc_pkg::SEQ_DONE;
			end
			ltc_pkg::SEQ_FIN_MUL: begin
				seq_d = ltc_pkg::SEQ_FIN_CHK;
			end
			ltc_pkg::SEQ_FIN_CHK: begin
				fin_d = fin_chk;
				st_d  = ltc_pkg::RS_STOP;
				seq_d = ltc_pkg::SEQ_DONE;
			end
			ltc_pkg::SEQ_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					seq_d    = ltc_pkg::SEQ_IDLE;
				end
			end
			default: begin
				seq_d = ltc_pkg::SEQ_IDLE;
			end
		endcase
	end

	// timeline state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			tl_q    <= '0;
			lp_q    <= '0;
			st_q    <= ltc_pkg::RS_STOP;
			fin_q   <= 1'b0;
		end else begin
			total_q <= total_d;
			tl_q    <= tl_d;
			lp_q    <= lp_d;
			st_q    <= st_d;
			fin_q   <= fin_d;
		end
	end

	// item capture, products
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q     <= ltc_pkg::op_t'(op);
			delta_q  <= delta_ms;
			seek_q   <= seek_ms;
			old_lp_q <= lp_q;
		end
		if (seq_q == ltc_pkg::SEQ_MUL)
			prod_q <= 32'(dur_q) * 32'(lc_q);
		if (seq_q == ltc_pkg::SEQ_FIN_MUL)
			fin_prod_q <= FP_BITS'(tl_q) * FP_BITS'(lp_inc);
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			total_time_q   <= total_q;
			loop_time_q    <= TIME_BITS'(tl_q);
			loop_index_q   <= lp_q;
			run_state_q    <= st_q;
			loop_changed_q <= (lp_q != old_lp_q);
			finished_q     <= fin_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign total_time   = total_time_q;
	assign loop_time    = loop_time_q;
	assign loop_index   = loop_index_q;
	assign run_state    = run_state_q;
	assign loop_changed = loop_changed_q;
	assign finished     = finished_q;

	// divider completes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (seq_q == ltc_pkg::SEQ_DIV))
		else $error("divider done outside divide phase");

	// a completion is only reported together with the stopped state
	a_fin_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		((seq_q == ltc_pkg::SEQ_DONE) && fin_q) |-> (st_q == ltc_pkg::RS_STOP))
		else $error("finished without stop");

	// a bounded timeline never holds a total past its end
	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		((seq_q == ltc_pkg::SEQ_SPLIT) && !unbounded) |-> (total_q <= tdur))
		else $error("total beyond total duration");

	// time in loop never exceeds one loop
	a_tl_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		((seq_q == ltc_pkg::SEQ_SPLIT) && dur_pos) |=> (tl_q <= TL_BITS'(dur_mag)))
		else $error("time in loop exceeds duration");

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TB_TIME_BITS = 30;
	localparam longint TIME_CAP = (longint'(1) << TB_TIME_BITS) - 1;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE_CYCLES = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES = 20;
	localparam int PHASE_ITEMS = 95;

	typedef struct packed {
		logic [ltc_pkg::OP_BITS-1:0]    op;
		logic [ltc_pkg::DELTA_BITS-1:0] delta;
		logic [ltc_pkg::SEEK_BITS-1:0]  seek;
	} timeline_cmd_t;

	typedef struct packed {
		logic [TB_TIME_BITS-1:0]        total;
		logic [TB_TIME_BITS-1:0]        in_loop;
		logic [ltc_pkg::LOOP_BITS-1:0]  loop;
		logic [ltc_pkg::RS_BITS-1:0]    state;
		logic                           changed;
		logic                           fin;
	} timeline_view_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [ltc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [ltc_pkg::DUR_BITS-1:0]     cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [ltc_pkg::OP_BITS-1:0]      op = '0;
	logic [ltc_pkg::DELTA_BITS-1:0]   delta_ms = '0;
	logic [ltc_pkg::SEEK_BITS-1:0]    seek_ms = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [TB_TIME_BITS-1:0]          total_time;
	logic [TB_TIME_BITS-1:0]          loop_time;
	logic [ltc_pkg::LOOP_BITS-1:0]    loop_index;
	logic [ltc_pkg::RS_BITS-1:0]      run_state;
	logic                             loop_changed;
	logic                             finished;

	looping_timeline_counter #(.TIME_BITS(TB_TIME_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.delta_ms(delta_ms),
		.seek_ms(seek_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total_time(total_time),
		.loop_time(loop_time),
		.loop_index(loop_index),
		.run_state(run_state),
		.loop_changed(loop_changed),
		.finished(finished)
	);

	// clock and the single reset pulse
	always #2 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// shadow copy of registers and timeline state
	longint              cfg_dur = 0;
	longint              cfg_loops = 1;
	bit                  cfg_dir = 1'b0;
	longint              tl_total = 0;
	longint              tl_in_loop = 0;
	longint              tl_loop = 0;
	ltc_pkg::run_state_t tl_state = ltc_pkg::RS_STOP;
	bit                  tl_fin = 1'b0;

	timeline_cmd_t  pending_ops[$];
	timeline_view_t due_results[$];
	timeline_cmd_t  cur_cmd = '0;
	int  items_queued = 0;
	int  items_accepted = 0;
	int  fail_count = 0;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	int  tx_gap = 0;
	int  rx_stall_left = 0;
	bit  tx_burst = 1'b0;
	bit  rx_burst = 1'b0;
	bit  tx_take;
	int  quiet_cycles = 0;

	function automatic longint sat_time(longint t);
		if (t < 0)
			return 0;
		if (t > TIME_CAP)
			return TIME_CAP;
		return t;
	endfunction

	// stop, deciding whether it counts as completion
	function automatic void halt_timeline();
		if (tl_state == ltc_pkg::RS_STOP || cfg_loops == 0)
			return;
		if (cfg_dur == -1 || cfg_loops < 0
			|| (!cfg_dir && tl_in_loop * (tl_loop + 1) == cfg_dur * cfg_loops)
			|| (cfg_dir && tl_in_loop == 0))
			tl_fin = 1'b1;
		tl_state = ltc_pkg::RS_STOP;
	endfunction

	// clamp a target time and split it into loop number and time in loop
	function automatic void place_time(longint t);
		bit     unbounded;
		longint span;
		longint lp;
		unbounded = (cfg_dur == -1) || (cfg_dur > 0 && cfg_loops < 0);
		span = 0;
		if (cfg_dur > 0 && cfg_loops >= 0)
			span = sat_time(cfg_dur * cfg_loops);
		t = sat_time(t);
		if (!unbounded && t > span)
			t = span;
		tl_total = t;
		lp = (cfg_dur <= 0) ? 0 : t / cfg_dur;
		if (lp == cfg_loops) begin
			tl_in_loop = (cfg_dur > 0) ? cfg_dur : 0;
			lp = (cfg_loops - 1 > 0) ? cfg_loops - 1 : 0;
		end else if (cfg_dur <= 0) begin
			tl_in_loop = t;
		end else if (!cfg_dir) begin
			tl_in_loop = t % cfg_dur;
		end else begin
			// backward: a loop boundary belongs to the loop below it
			tl_in_loop = (t == 0) ? 0 : ((t - 1) % cfg_dur) + 1;
			if (tl_in_loop == cfg_dur)
				lp--;
		end
		if (lp > longint'(ltc_pkg::LOOP_MAX))
			lp = longint'(ltc_pkg::LOOP_MAX);
		if (lp < 0)
			lp = 0;
		tl_loop = lp;
		if ((!cfg_dir && !unbounded && tl_total == span) || (cfg_dir && tl_total == 0))
			halt_timeline();
	endfunction

	// run state change with rewind from stopped
	function automatic void change_state(ltc_pkg::run_state_t next);
		ltc_pkg::run_state_t prev;
		longint              rewind;
		prev = tl_state;
		if (prev == next || cfg_loops == 0)
			return;
		if (next == ltc_pkg::RS_STOP) begin
			halt_timeline();
			return;
		end
		if (prev == ltc_pkg::RS_STOP) begin
			rewind = 0;
			if (cfg_dir) begin
				if (cfg_loops == -1)
					rewind = cfg_dur;
				else if (cfg_dur <= 0)
					rewind = cfg_dur;
				else if (cfg_loops < 0)
					rewind = 0;
				else
					rewind = cfg_dur * cfg_loops;
			end
			rewind = sat_time(rewind);
			tl_total = rewind;
			tl_in_loop = rewind;
		end
		tl_state = next;
		if (next == ltc_pkg::RS_RUN && prev == ltc_pkg::RS_STOP)
			place_time(tl_total);
	endfunction

	// expected result of one accepted command
	function automatic timeline_view_t step_timeline(timeline_cmd_t c);
		timeline_view_t v;
		longint         prev_loop;
		longint         step;
		prev_loop = tl_loop;
		step = longint'(c.delta);
		tl_fin = 1'b0;
		case (c.op)
			ltc_pkg::OP_TICK: begin
				if (tl_state == ltc_pkg::RS_RUN && c.delta != 0)
					place_time(cfg_dir ? tl_total - step : tl_total + step);
			end
			ltc_pkg::OP_START: begin
				if (tl_state != ltc_pkg::RS_RUN)
					change_state(ltc_pkg::RS_RUN);
			end
			ltc_pkg::OP_STOP: begin
				if (tl_state != ltc_pkg::RS_STOP)
					change_state(ltc_pkg::RS_STOP);
			end
			ltc_pkg::OP_PAUSE: begin
				if (tl_state != ltc_pkg::RS_STOP)
					change_state(ltc_pkg::RS_PAUSE);
			end
			ltc_pkg::OP_RESUME: begin
				if (tl_state == ltc_pkg::RS_PAUSE)
					change_state(ltc_pkg::RS_RUN);
			end
			ltc_pkg::OP_SEEK: begin
				place_time(longint'(c.seek));
			end
			default: ;
		endcase
		v.total = tl_total[TB_TIME_BITS-1:0];
		v.in_loop = tl_in_loop[TB_TIME_BITS-1:0];
		v.loop = tl_loop[ltc_pkg::LOOP_BITS-1:0];
		v.state = tl_state;
		v.changed = (tl_loop != prev_loop);
		v.fin = tl_fin;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	// sender: one transaction at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= '0;
			delta_ms <= '0;
			seek_ms <= '0;
			tx_gap = 0;
		end else begin
			tx_take = in_valid && !in_stall;
			if (tx_take) begin
				due_results.push_back(step_timeline(cur_cmd));
				items_accepted++;
			end
			if (!in_valid || tx_take) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					cur_cmd = pending_ops.pop_front();
					op <= cur_cmd.op;
					delta_ms <= cur_cmd.delta;
					seek_ms <= cur_cmd.seek;
					in_valid <= 1'b1;
					if ($urandom_range(0, 59) == 0)
						tx_burst = !tx_burst;
					tx_gap = tx_burst ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// receiver: check each result transaction and pace out_stall
	always @(posedge clk or negedge arst_n) begin
		timeline_view_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			rx_stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("total_time", want.total, total_time);
					check_field("loop_time", want.in_loop, loop_time);
					check_field("loop_index", want.loop, loop_index);
					check_field("run_state", want.state, run_state);
					check_field("loop_changed", want.changed, loop_changed);
					check_field("finished", want.fin, finished);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_served != hold_requests) begin
				// long hold-off so the block backs up into its input
				hold_served++;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 79) == 0)
					rx_burst = !rx_burst;
				rx_stall_left = rx_burst ? 0 : pick_gap();
				out_stall <= (rx_stall_left > 0);
				if (rx_stall_left > 0)
					rx_stall_left--;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void queue_cmd(logic [ltc_pkg::OP_BITS-1:0] o,
		logic [ltc_pkg::DELTA_BITS-1:0] d, logic [ltc_pkg::SEEK_BITS-1:0] s);
		timeline_cmd_t c;
		c.op = o;
		c.delta = d;
		c.seek = s;
		pending_ops.push_back(c);
		items_queued++;
	endfunction

	function automatic logic [ltc_pkg::DELTA_BITS-1:0] pick_delta();
		int     r;
		longint span;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 15 || cfg_dur <= 0)
			return ltc_pkg::DELTA_BITS'($urandom);
		if (r < 25)
			return (cfg_dur > 65535) ? '1 : ltc_pkg::DELTA_BITS'(cfg_dur);
		span = cfg_dur * 2;
		if (span > 65535)
			span = 65535;
		return ltc_pkg::DELTA_BITS'($urandom_range(1, int'(span)));
	endfunction

	// seek targets cluster around loop boundaries
	function automatic logic [ltc_pkg::SEEK_BITS-1:0] pick_seek();
		int     r;
		longint k;
		longint t;
		r = $urandom_range(0, 99);
		if (r < 15)
			return ltc_pkg::SEEK_BITS'($urandom);
		if (cfg_dur <= 0)
			return (r < 50) ? ltc_pkg::SEEK_BITS'($urandom)
			                : ltc_pkg::SEEK_BITS'($urandom_range(0, 100));
		k = (cfg_loops > 0) ? $urandom_range(0, int'(cfg_loops)) : $urandom_range(0, 40);
		t = k * cfg_dur + longint'($urandom_range(0, 2)) - 1;
		if (t < 0)
			t = 0;
		return t[ltc_pkg::SEEK_BITS-1:0];
	endfunction

	function automatic longint pick_dur();
		case ($urandom_range(0, 9))
			0: return -1;
			1: return 0;
			2: return 1048575;
			3: return -longint'($urandom_range(2, 1048576));
			4, 5: return $urandom_range(1, 20);
			6, 7: return $urandom_range(21, 2000);
			default: return $urandom_range(1, 1048575);
		endcase
	endfunction

	function automatic longint pick_loops();
		case ($urandom_range(0, 9))
			0: return -1;
			1: return 0;
			2: return 1;
			3: return 1023;
			4: return -longint'($urandom_range(2, 1024));
			5, 6, 7: return $urandom_range(2, 6);
			default: return $urandom_range(7, 1023);
		endcase
	endfunction

	// mostly start / tick / seek runs, some noise
	function automatic void queue_random_phase(int n);
		int target;
		int len;
		int s;
		target = items_queued + n;
		while (items_queued < target) begin
			if ($urandom_range(0, 99) < 80) begin
				queue_cmd(ltc_pkg::OP_START, ltc_pkg::DELTA_BITS'($urandom),
					ltc_pkg::SEEK_BITS'($urandom));
				len = $urandom_range(3, 15);
				repeat (len) begin
					s = $urandom_range(0, 99);
					if (s < 65)
						queue_cmd(ltc_pkg::OP_TICK, pick_delta(),
							ltc_pkg::SEEK_BITS'($urandom));
					else if (s < 80)
						queue_cmd(ltc_pkg::OP_SEEK, ltc_pkg::DELTA_BITS'($urandom),
							pick_seek());
					else if (s < 88)
						queue_cmd(ltc_pkg::OP_PAUSE, ltc_pkg::DELTA_BITS'($urandom),
							ltc_pkg::SEEK_BITS'($urandom));
					else if (s < 95)
						queue_cmd(ltc_pkg::OP_RESUME, ltc_pkg::DELTA_BITS'($urandom),
							ltc_pkg::SEEK_BITS'($urandom));
					else
						queue_cmd(ltc_pkg::OP_START, ltc_pkg::DELTA_BITS'($urandom),
							ltc_pkg::SEEK_BITS'($urandom));
				end
				if ($urandom_range(0, 1))
					queue_cmd(ltc_pkg::OP_STOP, ltc_pkg::DELTA_BITS'($urandom),
						ltc_pkg::SEEK_BITS'($urandom));
			end else begin
				queue_cmd(ltc_pkg::OP_BITS'($urandom), ltc_pkg::DELTA_BITS'($urandom),
					ltc_pkg::SEEK_BITS'($urandom));
			end
		end
	endfunction

	// wait until every transaction is in and every result is out
	task automatic drain();
		while (items_accepted != items_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [ltc_pkg::CFG_IDX_BITS-1:0] idx, input longint value);
		logic [ltc_pkg::DUR_BITS-1:0] word;
		word = value[ltc_pkg::DUR_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ltc_pkg::CFG_DURATION: cfg_dur = longint'($signed(word));
			ltc_pkg::CFG_LOOP_COUNT: cfg_loops = longint'($signed(word[ltc_pkg::LC_BITS-1:0]));
			default: cfg_dir = word[0];
		endcase
	endtask

	task automatic apply_setting(input longint d, input longint lc, input bit dir);
		drain();
		write_cfg(ltc_pkg::CFG_DURATION, d);
		write_cfg(ltc_pkg::CFG_LOOP_COUNT, lc);
		write_cfg(ltc_pkg::CFG_DIRECTION, longint'(dir));
	endtask

	// stimulus: directed cases, then random phases
	initial begin
		longint fix_dur[8];
		longint fix_loops[8];
		bit     fix_dir[8];
		fix_dur = '{1048575, 1, -1, 7, -5, 13, 1048575, 3};
		fix_loops = '{1023, 1, 5, -1, 3, 0, -1024, 1023};
		fix_dir = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		while (!arst_n)
			@(posedge clk);

		// reset settings: zero duration ends at once, unused ops do nothing
		queue_cmd(ltc_pkg::OP_TICK, 16'd5, '0);
		queue_cmd(ltc_pkg::OP_START, '0, '0);
		queue_cmd(3'd6, '1, '1);
		queue_cmd(3'd7, '1, '1);

		// forward: zero tick, pause ignoring ticks, clamp at end, ignored stop/pause
		apply_setting(100, 3, 1'b0);
		queue_cmd(ltc_pkg::OP_START, '0, '0);
		queue_cmd(ltc_pkg::OP_TICK, 16'd0, '0);
		queue_cmd(ltc_pkg::OP_TICK, 16'd250, '0);
		queue_cmd(ltc_pkg::OP_PAUSE, '0, '0);
		queue_cmd(ltc_pkg::OP_TICK, 16'd10, '0);
		queue_cmd(ltc_pkg::OP_RESUME, '0, '0);
		queue_cmd(ltc_pkg::OP_TICK, 16'hFFFF, '0);
		queue_cmd(ltc_pkg::OP_SEEK, '0, 30'h3FFFFFFF);
		queue_cmd(ltc_pkg::OP_STOP, '0, '0);
		queue_cmd(ltc_pkg::OP_PAUSE, '0, '0);

		// backward: rewind to the end, loop boundary falls to the lower loop
		apply_setting(100, 3, 1'b1);
		queue_cmd(ltc_pkg::OP_START, '0, '0);
		queue_cmd(ltc_pkg::OP_SEEK, '0, 30'd200);
		queue_cmd(ltc_pkg::OP_TICK, 16'hFFFF, '0);

		// unbounded duration, loops forever, time saturates
		apply_setting(-1, -1, 1'b1);
		queue_cmd(ltc_pkg::OP_START, '0, '0);
		queue_cmd(ltc_pkg::OP_SEEK, '0, 30'h3FFFFFFF);
		queue_cmd(ltc_pkg::OP_RESUME, '0, '0);

		// largest duration and loop count
		apply_setting(1048575, 1023, 1'b0);
		queue_cmd(ltc_pkg::OP_START, '0, '0);
		queue_cmd(ltc_pkg::OP_SEEK, '0, 30'd1072692224);
		queue_cmd(ltc_pkg::OP_TICK, 16'hFFFF, '0);

		// zero loop count keeps the run state
		apply_setting(5, 0, 1'b0);
		queue_cmd(ltc_pkg::OP_START, '0, '0);
		queue_cmd(ltc_pkg::OP_SEEK, '0, 30'd12);
		queue_cmd(ltc_pkg::OP_STOP, '0, '0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 8)
				apply_setting(fix_dur[p], fix_loops[p], fix_dir[p]);
			else
				apply_setting(pick_dur(), pick_loops(), 1'($urandom_range(0, 1)));
			queue_random_phase(PHASE_ITEMS);
			if (p == 3 || p == 12)
				hold_requests++;
		end

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
